[rtl/cenc_pkg.sv]
// ----------------------------------------------------------------------------
// cenc_pkg
// Shared types and constants of the streaming COBS frame encoder.
// ----------------------------------------------------------------------------
package cenc_pkg;

  localparam int unsigned IdxW      = 8;
  localparam int unsigned RamAddrW  = IdxW + 1;
  localparam int unsigned RamDepth  = 2 ** RamAddrW;

  localparam logic [IdxW-1:0] BlockMax = 8'd254;
  localparam logic [7:0]      FullCode = 8'hFF;
  localparam logic [7:0]      EndCode  = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        frame_done;
    logic        run_last;
  } result_t;

  // One block flush: which bank holds the bytes, how many, and what follows.
  typedef struct packed {
    logic            bank;
    logic [IdxW-1:0] count;
    logic            append_end;
    logic            frame_end;
  } cmd_t;

endpackage

[rtl/cobs_frame_encoder.sv]
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// Streaming COBS encoder with packed multi-byte results.
// ----------------------------------------------------------------------------
// Input side is a queue: drive item_i and raise push; the byte is taken at a
// clock edge with push high and full low. Results come out of a queue: while
// empty is low, result_o shows the oldest result; raise pop to take it.
// One raw byte is taken per cycle while full is low. Nonzero bytes go into
// one of two block banks; a closing byte (zero, 254th byte of a block, or
// frame end) hands the bank to the back end and switches to the other bank.
// The back end sends one encoded byte per cycle while its result queue is
// not full. full rises while both banks wait to be sent; that is the only
// input stall. A stalled receiver backs up the two-entry result queue, then
// the back end, then the banks. Reset empties both queues and clears the
// fill count; the block store needs no clearing pass.
// ----------------------------------------------------------------------------
module cobs_frame_encoder #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  cenc_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output cenc_pkg::result_t result_o
);

  logic                          take;
  logic                          we;
  logic [cenc_pkg::RamAddrW-1:0] waddr, raddr;
  logic [7:0]                    wdata, rdata;
  logic                          cmd_push, cmd_valid, cmd_pop;
  cenc_pkg::cmd_t                cmd_new, cmd_head;

  assign take = push && !full;

  cenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_new)
  );

  cenc_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_new),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .head_o  (cmd_head)
  );

  cenc_ram #(
    .Width (8),
    .Depth (cenc_pkg::RamDepth)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cenc_back #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

[rtl/cenc_ram.sv]
// ----------------------------------------------------------------------------
// cenc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cenc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cenc_front.sv]
// ----------------------------------------------------------------------------
// cenc_front
// Takes raw bytes, stores nonzero ones in the current bank and decides when
// a block closes, then posts a flush command for the back end.
// ----------------------------------------------------------------------------
module cenc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  cenc_pkg::item_t               item_i,
  output logic                          we_o,
  output logic [cenc_pkg::RamAddrW-1:0] waddr_o,
  output logic [7:0]                    wdata_o,
  output logic                          cmd_push_o,
  output cenc_pkg::cmd_t                cmd_o
);

  logic [cenc_pkg::IdxW-1:0] fill_q, fill_d, fill_inc;
  logic                      bank_q, bank_d;
  logic                      nonzero;

  assign nonzero  = (item_i.data_byte != 8'd0);
  assign fill_inc = fill_q + 1'b1;

  assign we_o    = take_i && nonzero;
  assign waddr_o = {bank_q, fill_q};
  assign wdata_o = item_i.data_byte;

  always_comb begin
    fill_d     = fill_q;
    bank_d     = bank_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.bank = bank_q;
    if (take_i) begin
      if (nonzero) begin
        cmd_o.count     = fill_inc;
        cmd_o.frame_end = item_i.end_of_frame;
        if (fill_inc == cenc_pkg::BlockMax || item_i.end_of_frame) begin
          cmd_push_o = 1'b1;
        end
        fill_d = fill_inc;
      end else begin
        // a zero byte always closes the block
        cmd_o.count      = fill_q;
        cmd_o.append_end = item_i.end_of_frame;
        cmd_o.frame_end  = item_i.end_of_frame;
        cmd_push_o       = 1'b1;
      end
      if (cmd_push_o) begin
        fill_d = '0;
        bank_d = ~bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
    end
  end

endmodule

[rtl/cenc_cmd_queue.sv]
// ----------------------------------------------------------------------------
// cenc_cmd_queue
// Two-entry queue of flush commands. An entry stays until the back end has
// sent its whole block, so the count also tells how many banks are busy.
// ----------------------------------------------------------------------------
module cenc_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cenc_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cenc_pkg::cmd_t head_o
);

  cenc_pkg::cmd_t entry_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = entry_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/cenc_back.sv]
// ----------------------------------------------------------------------------
// cenc_back
// Walks one flush command byte by byte (code, stored bytes, optional end code),
// packs the bytes into result words and queues them for the receiver.
// ----------------------------------------------------------------------------
module cenc_back #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  cenc_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic [cenc_pkg::RamAddrW-1:0] raddr_o,
  input  logic [7:0]                    rdata_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output cenc_pkg::result_t             result_o
);

  localparam logic [3:0] PackMax = 4'(BYTES_PER_RESULT);

  logic [cenc_pkg::IdxW-1:0] idx_q, idx_d, s1_idx_q, last_idx;
  logic                      s0_done_q, s0_done_d, s1_vld_q;
  logic                      adv, issue, s1_last, flush;
  logic [7:0]                code, byte_val;
  logic [63:0]               pack_word_q, word_new;
  logic [3:0]                pack_cnt_q, cnt_new;

  cenc_pkg::result_t oq_q [2];
  cenc_pkg::result_t res_new;
  logic              owp_q, orp_q, oq_full, oq_push, oq_pop;
  logic [1:0]        ocnt_q;

  assign oq_full = (ocnt_q == 2'd2);
  assign adv     = !oq_full;

  assign last_idx = cmd_i.count + {{(cenc_pkg::IdxW-1){1'b0}}, cmd_i.append_end};
  assign issue    = cmd_valid_i && !s0_done_q && adv;
  assign s1_last  = (s1_idx_q == last_idx);

  always_comb begin
    idx_d     = idx_q;
    s0_done_d = s0_done_q;
    if (issue) begin
      if (idx_q == last_idx) begin
        idx_d     = '0;
        s0_done_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (cmd_pop_o) begin
      s0_done_d = 1'b0;
    end
  end

  // While stalled, re-read the byte held in stage one so rdata stays valid.
  assign raddr_o = adv ? {cmd_i.bank, idx_q - 1'b1} : {cmd_i.bank, s1_idx_q - 1'b1};

  assign code = (cmd_i.count == cenc_pkg::BlockMax) ? cenc_pkg::FullCode
                                                     : cmd_i.count + 1'b1;

  always_comb begin
    if (s1_idx_q == '0) begin
      byte_val = code;
    end else if (s1_idx_q <= cmd_i.count) begin
      byte_val = rdata_i;
    end else begin
      byte_val = cenc_pkg::EndCode;
    end
  end

  always_comb begin
    word_new = pack_word_q;
    word_new[{pack_cnt_q[2:0], 3'b000} +: 8] = byte_val;
  end

  assign cnt_new   = pack_cnt_q + 4'd1;
  assign flush     = (cnt_new == PackMax) || s1_last;
  assign cmd_pop_o = adv && s1_vld_q && s1_last;
  assign oq_push   = adv && s1_vld_q && flush;
  assign oq_pop    = pop_i && !empty_o;

  always_comb begin
    res_new            = '0;
    res_new.out_bytes  = word_new;
    res_new.byte_count = cnt_new;
    res_new.frame_done = s1_last && cmd_i.frame_end;
    res_new.run_last   = s1_last;
  end

  assign empty_o  = (ocnt_q == 2'd0);
  assign result_o = oq_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[owp_q] <= res_new;
    end
    if (adv) begin
      s1_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s0_done_q   <= 1'b0;
      s1_vld_q    <= 1'b0;
      pack_word_q <= '0;
      pack_cnt_q  <= '0;
      owp_q       <= 1'b0;
      orp_q       <= 1'b0;
      ocnt_q      <= '0;
    end else begin
      idx_q     <= idx_d;
      s0_done_q <= s0_done_d;
      if (adv) begin
        s1_vld_q <= issue;
      end
      if (adv && s1_vld_q) begin
        if (flush) begin
          pack_word_q <= '0;
          pack_cnt_q  <= '0;
        end else begin
          pack_word_q <= word_new;
          pack_cnt_q  <= cnt_new;
        end
      end
      if (oq_push) owp_q <= ~owp_q;
      if (oq_pop)  orp_q <= ~orp_q;
      if (oq_push && !oq_pop) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (oq_pop && !oq_push) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

endmodule

[rtl/cenc_checker.sv]
// ----------------------------------------------------------------------------
// cenc_checker
// Port-level checks of the COBS frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cenc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input cenc_pkg::result_t result_o
);

  // hold a waiting result until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed before transfer");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.byte_count != 4'd0 && result_o.byte_count <= 4'd8))
    else $error("byte_count out of range");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.frame_done) |-> result_o.run_last)
    else $error("frame_done without run_last");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.byte_count <= 4'd7) |-> (result_o.out_bytes[63:56] == 8'd0))
    else $error("bytes above byte_count not zero");

endmodule

bind cobs_frame_encoder cenc_checker u_cenc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
